[hdl/ccs_pkg.sv]
package ccs_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 18;
  localparam int PipeDepth = 8 + 2 * SqrtSteps + DivSteps + 7;
  localparam int CfgIdxW   = 2;

  localparam logic [16:0] StiffReset = 17'd65536;
  localparam logic [17:0] AttOne     = 18'd65536;
  localparam logic signed [17:0] FacOne = 18'sd65536;
  localparam logic signed [63:0] HalfQ14 = 64'sd8192;
  localparam logic signed [63:0] HalfQ16 = 64'sd32768;

  typedef enum logic [CfgIdxW-1:0] {
    RegOffX  = 2'd0,
    RegOffY  = 2'd1,
    RegOffZ  = 2'd2,
    RegStiff = 2'd3
  } cfg_reg_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (!v[63] && (v[62:31] != '0)) return 32'sh7FFF_FFFF;
    if (v[63] && (v[62:31] != '1)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

[hdl/contact_constraint_solve_unit.sv]
// Contact constraint solver for two points in Q16.16. Takes one word per cycle unless
// the output stalls, and returns one result word per input word, in order; each word
// passes two 32-stage square root pipelines in series and 18-stage dividers. A
// stalled output holds the whole pipeline. Configuration writes are taken at any
// time and must land while no word is in flight.
module contact_constraint_solve_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ccs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [31:0]           pos_a_x_i,
  input  logic signed [31:0]           pos_a_y_i,
  input  logic signed [31:0]           pos_a_z_i,
  input  logic signed [31:0]           pos_b_x_i,
  input  logic signed [31:0]           pos_b_y_i,
  input  logic signed [31:0]           pos_b_z_i,
  input  logic signed [15:0]           normal_x_i,
  input  logic signed [15:0]           normal_y_i,
  input  logic signed [15:0]           normal_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           new_b_x_o,
  output logic signed [31:0]           new_b_y_o,
  output logic signed [31:0]           new_b_z_o,
  output logic [31:0]                  correction_size_o
);
  import ccs_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [2:0][31:0] b;
    logic [2:0][31:0] d;
    logic [2:0][31:0] p;
    logic [2:0][31:0] q;
    logic [47:0]      ad;
  } sb1_t;

  typedef struct packed {
    logic             kind;
    logic [2:0][31:0] b;
    logic [2:0][31:0] d;
    logic [2:0][31:0] p;
    logic [2:0][31:0] q;
    logic             gt;
    logic             dz;
  } sb2_t;

  typedef struct packed {
    logic             kind;
    logic [2:0][31:0] nb;
    logic [19:0]      str;
  } sb3_t;

  logic adv;
  logic [PipeDepth-1:0] vld_q;

  logic signed [31:0] off_q [3];
  logic [16:0]        stiff_q;

  assign adv         = ~vld_q[PipeDepth-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[PipeDepth-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
      stiff_q  <= StiffReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegOffX:  off_q[0] <= cfg_data_i;
        RegOffY:  off_q[1] <= cfg_data_i;
        RegOffZ:  off_q[2] <= cfg_data_i;
        RegStiff: stiff_q  <= cfg_data_i[16:0];
        default:  ;
      endcase
    end
  end

  // error vector and clamped normal
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [15:0] nr [3];
  logic signed [31:0] d0 [3];
  logic signed [15:0] n0 [3];

  assign pa[0] = pos_a_x_i;
  assign pa[1] = pos_a_y_i;
  assign pa[2] = pos_a_z_i;
  assign pb[0] = pos_b_x_i;
  assign pb[1] = pos_b_y_i;
  assign pb[2] = pos_b_z_i;
  assign nr[0] = normal_x_i;
  assign nr[1] = normal_y_i;
  assign nr[2] = normal_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0[i] = sat32(64'(pa[i]) + 64'(off_q[i]) - 64'(pb[i]));
      if (nr[i] > 16'sd16384) n0[i] = 16'sd16384;
      else if (nr[i] < -16'sd16384) n0[i] = -16'sd16384;
      else n0[i] = nr[i];
    end
  end

  logic               s1_kind_q, s2_kind_q, s3_kind_q, s4_kind_q;
  logic               s5_kind_q, s6_kind_q, s7_kind_q, s8_kind_q;
  logic signed [31:0] s1_b_q [3], s2_b_q [3], s3_b_q [3], s4_b_q [3];
  logic signed [31:0] s5_b_q [3], s6_b_q [3], s7_b_q [3], s8_b_q [3];
  logic signed [31:0] s1_d_q [3], s2_d_q [3], s3_d_q [3], s4_d_q [3];
  logic signed [31:0] s5_d_q [3], s6_d_q [3], s7_d_q [3], s8_d_q [3];
  logic signed [15:0] s1_n_q [3], s2_n_q [3], s3_n_q [3];
  logic signed [47:0] s2_pdn_q [3], s2_pof_q [3];
  logic [63:0]        s2_osq_q [3];
  logic signed [31:0] s3_dn_q;
  logic [47:0]        s3_ad_q, s4_ad_q, s5_ad_q, s6_ad_q, s7_ad_q, s8_ad_q;
  logic [63:0]        s3_os_q, s4_os_q, s5_os_q, s6_os_q, s7_os_q, s8_os_q;
  logic signed [47:0] s4_pp_q [3];
  logic signed [31:0] s5_p_q [3], s6_p_q [3], s7_p_q [3], s8_p_q [3];
  logic signed [31:0] s6_q_q [3], s7_q_q [3], s8_q_q [3];
  logic [63:0]        s7_psq_q [3], s7_qsq_q [3];
  logic [63:0]        s8_sp_q, s8_sq_q;
  logic signed [63:0] dn_sum, of_sum;

  assign dn_sum = 64'(s2_pdn_q[0]) + 64'(s2_pdn_q[1]) + 64'(s2_pdn_q[2]) + HalfQ14;
  assign of_sum = 64'(s2_pof_q[0]) + 64'(s2_pof_q[1]) + 64'(s2_pof_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= kind_i;
      s2_kind_q <= s1_kind_q;
      s3_kind_q <= s2_kind_q;
      s4_kind_q <= s3_kind_q;
      s5_kind_q <= s4_kind_q;
      s6_kind_q <= s5_kind_q;
      s7_kind_q <= s6_kind_q;
      s8_kind_q <= s7_kind_q;
      for (int i = 0; i < 3; i++) begin
        s1_b_q[i] <= pb[i];
        s2_b_q[i] <= s1_b_q[i];
        s3_b_q[i] <= s2_b_q[i];
        s4_b_q[i] <= s3_b_q[i];
        s5_b_q[i] <= s4_b_q[i];
        s6_b_q[i] <= s5_b_q[i];
        s7_b_q[i] <= s6_b_q[i];
        s8_b_q[i] <= s7_b_q[i];
        s1_d_q[i] <= d0[i];
        s2_d_q[i] <= s1_d_q[i];
        s3_d_q[i] <= s2_d_q[i];
        s4_d_q[i] <= s3_d_q[i];
        s5_d_q[i] <= s4_d_q[i];
        s6_d_q[i] <= s5_d_q[i];
        s7_d_q[i] <= s6_d_q[i];
        s8_d_q[i] <= s7_d_q[i];
        s1_n_q[i] <= n0[i];
        s2_n_q[i] <= s1_n_q[i];
        s3_n_q[i] <= s2_n_q[i];
        s2_pdn_q[i] <= 48'(s1_d_q[i]) * 48'(s1_n_q[i]);
        s2_pof_q[i] <= 48'(off_q[i]) * 48'(s1_n_q[i]);
        s2_osq_q[i] <= 64'(off_q[i]) * 64'(off_q[i]);
        s4_pp_q[i]  <= 48'(s3_dn_q) * 48'(s3_n_q[i]);
        s5_p_q[i]   <= sat32((64'(s4_pp_q[i]) + HalfQ14) >>> 14);
        s6_p_q[i]   <= s5_p_q[i];
        s7_p_q[i]   <= s6_p_q[i];
        s8_p_q[i]   <= s7_p_q[i];
        s6_q_q[i]   <= sat32(64'(s5_d_q[i]) - 64'(s5_p_q[i]));
        s7_q_q[i]   <= s6_q_q[i];
        s8_q_q[i]   <= s7_q_q[i];
        s7_psq_q[i] <= 64'(s6_p_q[i]) * 64'(s6_p_q[i]);
        s7_qsq_q[i] <= 64'(s6_q_q[i]) * 64'(s6_q_q[i]);
      end
      s3_dn_q <= sat32(dn_sum >>> 14);
      s3_ad_q <= of_sum[63] ? 48'(-of_sum) : 48'(of_sum);
      s3_os_q <= s2_osq_q[0] + s2_osq_q[1] + s2_osq_q[2];
      s4_ad_q <= s3_ad_q;
      s5_ad_q <= s4_ad_q;
      s6_ad_q <= s5_ad_q;
      s7_ad_q <= s6_ad_q;
      s8_ad_q <= s7_ad_q;
      s4_os_q <= s3_os_q;
      s5_os_q <= s4_os_q;
      s6_os_q <= s5_os_q;
      s7_os_q <= s6_os_q;
      s8_os_q <= s7_os_q;
      s8_sp_q <= s7_psq_q[0] + s7_psq_q[1] + s7_psq_q[2];
      s8_sq_q <= s7_qsq_q[0] + s7_qsq_q[1] + s7_qsq_q[2];
    end
  end

  // lengths of p, q and the rest offset
  logic [31:0] lp, lq, off_len, lf;

  ccs_sqrt u_sqrt_p (.clk_i, .en_i(adv), .rad_i(s8_sp_q), .root_o(lp));
  ccs_sqrt u_sqrt_q (.clk_i, .en_i(adv), .rad_i(s8_sq_q), .root_o(lq));
  ccs_sqrt u_sqrt_o (.clk_i, .en_i(adv), .rad_i(s8_os_q), .root_o(off_len));

  sb1_t sb1_in;
  sb1_t dl1_q [SqrtSteps];

  always_comb begin
    sb1_in.kind = s8_kind_q;
    sb1_in.ad   = s8_ad_q;
    for (int i = 0; i < 3; i++) begin
      sb1_in.b[i] = s8_b_q[i];
      sb1_in.d[i] = s8_d_q[i];
      sb1_in.p[i] = s8_p_q[i];
      sb1_in.q[i] = s8_q_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl1_q[0] <= sb1_in;
      for (int k = 1; k < SqrtSteps; k++) dl1_q[k] <= dl1_q[k-1];
    end
  end

  // friction factor and attenuation dividers, one quotient bit a stage
  sb1_t        t1;
  sb2_t        sb2_in;
  sb2_t        dl2_q [DivSteps];
  logic [49:0] dv_num [2];
  logic [31:0] dv_div [2];
  logic [31:0] dvr_q [2][DivSteps];
  logic [17:0] dvl_q [2][DivSteps];
  logic [31:0] dvd_q [2][DivSteps];
  logic [31:0] dvr_d [2][DivSteps];
  logic [17:0] dvl_d [2][DivSteps];
  logic [31:0] dvd_d [2][DivSteps];

  assign t1 = dl1_q[SqrtSteps-1];
  assign dv_num[0] = {2'b00, lp, 16'h0000};
  assign dv_div[0] = lq;
  assign dv_num[1] = {t1.ad, 2'b00};
  assign dv_div[1] = off_len;

  always_comb begin
    sb2_in.kind = t1.kind;
    sb2_in.b    = t1.b;
    sb2_in.d    = t1.d;
    sb2_in.p    = t1.p;
    sb2_in.q    = t1.q;
    sb2_in.gt   = lq > lp;
    sb2_in.dz   = off_len == 32'd0;
  end

  always_comb begin
    logic [31:0] rin, dv;
    logic [17:0] lin;
    logic [32:0] cand;
    logic        ge;
    for (int u = 0; u < 2; u++) begin
      for (int s = 0; s < DivSteps; s++) begin
        if (s == 0) begin
          rin = dv_num[u][49:18];
          lin = dv_num[u][17:0];
          dv  = dv_div[u];
        end else begin
          rin = dvr_q[u][(s == 0) ? 0 : s - 1];
          lin = dvl_q[u][(s == 0) ? 0 : s - 1];
          dv  = dvd_q[u][(s == 0) ? 0 : s - 1];
        end
        cand = {rin, lin[17]};
        ge   = cand >= {1'b0, dv};
        dvr_d[u][s] = ge ? 32'(cand - {1'b0, dv}) : cand[31:0];
        dvl_d[u][s] = {lin[16:0], ge};
        dvd_d[u][s] = dv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl2_q[0] <= sb2_in;
      for (int k = 1; k < DivSteps; k++) dl2_q[k] <= dl2_q[k-1];
      for (int u = 0; u < 2; u++) begin
        for (int s = 0; s < DivSteps; s++) begin
          dvr_q[u][s] <= dvr_d[u][s];
          dvl_q[u][s] <= dvl_d[u][s];
          dvd_q[u][s] <= dvd_d[u][s];
        end
      end
    end
  end

  // applied delta, strength and new B
  sb2_t               t2;
  logic               s10_kind_q, s11_kind_q, s12_kind_q, s13_kind_q, s14_kind_q;
  logic signed [31:0] s10_b_q [3], s11_b_q [3], s12_b_q [3], s13_b_q [3];
  logic signed [31:0] s10_d_q [3], s11_d_q [3];
  logic signed [31:0] s10_p_q [3], s11_p_q [3];
  logic signed [31:0] s10_q_q [3];
  logic signed [17:0] s10_fac_q;
  logic [17:0]        s10_att_q;
  logic signed [49:0] s11_fq_q [3];
  logic [34:0]        s11_sa_q;
  logic signed [31:0] s12_ds_q [3];
  logic [19:0]        s12_str_q, s13_str_q, s14_str_q;
  logic signed [52:0] s13_sd_q [3];
  logic [63:0]        s13_dsq_q [3];
  logic signed [31:0] s14_nb_q [3];
  logic [63:0]        s14_ds_q;
  logic [35:0]        str_sum;

  assign t2      = dl2_q[DivSteps-1];
  assign str_sum = 36'(s11_sa_q) + 36'd32768;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_kind_q <= t2.kind;
      s11_kind_q <= s10_kind_q;
      s12_kind_q <= s11_kind_q;
      s13_kind_q <= s12_kind_q;
      s14_kind_q <= s13_kind_q;
      s10_fac_q  <= t2.gt ? $signed(dvl_q[0][DivSteps-1]) - FacOne : 18'sd0;
      s10_att_q  <= t2.dz ? AttOne : dvl_q[1][DivSteps-1];
      s11_sa_q   <= 35'(stiff_q) * 35'(s10_att_q);
      s12_str_q  <= s11_kind_q ? str_sum[35:16] : 20'(stiff_q);
      s13_str_q  <= s12_str_q;
      s14_str_q  <= s13_str_q;
      for (int i = 0; i < 3; i++) begin
        s10_b_q[i]  <= $signed(t2.b[i]);
        s10_d_q[i]  <= $signed(t2.d[i]);
        s10_p_q[i]  <= $signed(t2.p[i]);
        s10_q_q[i]  <= $signed(t2.q[i]);
        s11_b_q[i]  <= s10_b_q[i];
        s12_b_q[i]  <= s11_b_q[i];
        s13_b_q[i]  <= s12_b_q[i];
        s11_d_q[i]  <= s10_d_q[i];
        s11_p_q[i]  <= s10_p_q[i];
        s11_fq_q[i] <= 50'(s10_fac_q) * 50'(s10_q_q[i]);
        s12_ds_q[i] <= s11_kind_q ?
                       sat32(64'(s11_p_q[i]) + ((64'(s11_fq_q[i]) + HalfQ16) >>> 16)) :
                       s11_d_q[i];
        s13_sd_q[i]  <= 53'($signed({1'b0, s12_str_q})) * 53'(s12_ds_q[i]);
        s13_dsq_q[i] <= 64'(s12_ds_q[i]) * 64'(s12_ds_q[i]);
        s14_nb_q[i]  <= sat32(64'(s13_b_q[i]) + ((64'(s13_sd_q[i]) + HalfQ16) >>> 16));
      end
      s14_ds_q <= s13_dsq_q[0] + s13_dsq_q[1] + s13_dsq_q[2];
    end
  end

  ccs_sqrt u_sqrt_f (.clk_i, .en_i(adv), .rad_i(s14_ds_q), .root_o(lf));

  sb3_t sb3_in;
  sb3_t dl3_q [SqrtSteps];

  always_comb begin
    sb3_in.kind = s14_kind_q;
    sb3_in.str  = s14_str_q;
    for (int i = 0; i < 3; i++) sb3_in.nb[i] = s14_nb_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl3_q[0] <= sb3_in;
      for (int k = 1; k < SqrtSteps; k++) dl3_q[k] <= dl3_q[k-1];
    end
  end

  // correction size
  sb3_t               t3;
  logic               s15_kind_q;
  logic [2:0][31:0]   s15_nb_q, s16_nb_q;
  logic [51:0]        s15_sl_q;
  logic [31:0]        s16_size_q;
  logic [52:0]        sl_rnd;

  assign t3     = dl3_q[SqrtSteps-1];
  assign sl_rnd = 53'(s15_sl_q) + 53'd32768;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s15_kind_q <= t3.kind;
      s15_nb_q   <= t3.nb;
      s15_sl_q   <= 52'(t3.str) * 52'(lf);
      s16_nb_q   <= s15_nb_q;
      if (!s15_kind_q) s16_size_q <= '0;
      else if (sl_rnd[52:48] != '0) s16_size_q <= '1;
      else s16_size_q <= sl_rnd[47:16];
    end
  end

  assign new_b_x_o         = $signed(s16_nb_q[0]);
  assign new_b_y_o         = $signed(s16_nb_q[1]);
  assign new_b_z_o         = $signed(s16_nb_q[2]);
  assign correction_size_o = s16_size_q;

endmodule

[hdl/ccs_sqrt.sv]
module ccs_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import ccs_pkg::*;

  logic [63:0] x_q   [SqrtSteps];
  logic [63:0] res_q [SqrtSteps];
  logic [63:0] x_d   [SqrtSteps];
  logic [63:0] res_d [SqrtSteps];

  always_comb begin
    logic [63:0] xin, rin, bt;
    for (int s = 0; s < SqrtSteps; s++) begin
      xin = (s == 0) ? rad_i : x_q[(s == 0) ? 0 : s - 1];
      rin = (s == 0) ? 64'd0 : res_q[(s == 0) ? 0 : s - 1];
      bt  = 64'd1 << (2 * (SqrtSteps - 1 - s));
      if (xin >= rin + bt) begin
        x_d[s]   = xin - (rin + bt);
        res_d[s] = (rin >> 1) + bt;
      end else begin
        x_d[s]   = xin;
        res_d[s] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SqrtSteps; s++) begin
        x_q[s]   <= x_d[s];
        res_q[s] <= res_d[s];
      end
    end
  end

  assign root_o = res_q[SqrtSteps-1][31:0];

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ccs_pkg::*;

  typedef struct {
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic [31:0]        size;
  } solve_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic signed [31:0] pos_a_x_i = '0, pos_a_y_i = '0, pos_a_z_i = '0;
  logic signed [31:0] pos_b_x_i = '0, pos_b_y_i = '0, pos_b_z_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] new_b_x_o, new_b_y_o, new_b_z_o;
  logic [31:0] correction_size_o;

  contact_constraint_solve_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  longint off_x, off_y, off_z, stiff;
  solve_res_t pending_q[$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned vec_len(longint v0, longint v1, longint v2);
    longint unsigned m0, m1, m2;
    m0 = (v0 < 0) ? -v0 : v0;
    m1 = (v1 < 0) ? -v1 : v1;
    m2 = (v2 < 0) ? -v2 : v2;
    return int_sqrt(m0 * m0 + m1 * m1 + m2 * m2);
  endfunction

  function automatic longint clamp_normal(logic signed [15:0] raw);
    longint v;
    v = raw;
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic solve_res_t solve_contact(
      logic kind, logic signed [31:0] a [3], logic signed [31:0] b [3],
      logic signed [15:0] nr [3]);
    longint off [3], d [3], n [3], p [3], q [3];
    longint dn, dot_o, fac, att, strength;
    longint unsigned lp, lq, off_len, lf, ad, sz;
    solve_res_t r;
    off[0] = off_x; off[1] = off_y; off[2] = off_z;
    sz = 0;
    for (int i = 0; i < 3; i++) d[i] = clamp32(longint'(a[i]) + off[i] - longint'(b[i]));
    if (!kind) begin
      strength = stiff;
    end else begin
      dn = 0;
      dot_o = 0;
      fac = 0;
      for (int i = 0; i < 3; i++) begin
        n[i] = clamp_normal(nr[i]);
        dn += d[i] * n[i];
        dot_o += off[i] * n[i];
      end
      dn = clamp32(round_shift(dn, 14));
      for (int i = 0; i < 3; i++) begin
        p[i] = clamp32(round_shift(dn * n[i], 14));
        q[i] = clamp32(d[i] - p[i]);
      end
      lp = vec_len(p[0], p[1], p[2]);
      lq = vec_len(q[0], q[1], q[2]);
      if (lq > lp) fac = longint'((lp << 16) / lq) - 65536;
      for (int i = 0; i < 3; i++) d[i] = clamp32(p[i] + round_shift(fac * q[i], 16));
      off_len = vec_len(off[0], off[1], off[2]);
      if (off_len > 0) begin
        ad = (dot_o < 0) ? -dot_o : dot_o;
        att = longint'((ad << 2) / off_len);
      end else begin
        att = 65536;
      end
      strength = round_shift(stiff * att, 16);
      lf = vec_len(d[0], d[1], d[2]);
      sz = longint'(round_shift(strength * longint'(lf), 16));
      if (sz > 64'hFFFF_FFFF) sz = 64'hFFFF_FFFF;
    end
    r.bx = 32'(clamp32(longint'(b[0]) + round_shift(strength * d[0], 16)));
    r.by = 32'(clamp32(longint'(b[1]) + round_shift(strength * d[1], 16)));
    r.bz = 32'(clamp32(longint'(b[2]) + round_shift(strength * d[2], 16)));
    r.size = sz[31:0];
    return r;
  endfunction

  always @(negedge clk_i) begin
    stall_cnt++;
    if (stall_cnt % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (stall_cnt % 4) != 0;
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    solve_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h", $time,
                 new_b_x_o, new_b_y_o, new_b_z_o, correction_size_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (new_b_x_o !== e.bx) begin
          $display("%0t: new_b_x expected %h actual %h", $time, e.bx, new_b_x_o);
          errors++;
        end
        if (new_b_y_o !== e.by) begin
          $display("%0t: new_b_y expected %h actual %h", $time, e.by, new_b_y_o);
          errors++;
        end
        if (new_b_z_o !== e.bz) begin
          $display("%0t: new_b_z expected %h actual %h", $time, e.bz, new_b_z_o);
          errors++;
        end
        if (correction_size_o !== e.size) begin
          $display("%0t: correction_size expected %h actual %h", $time, e.size,
                   correction_size_o);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic kind, logic signed [31:0] a [3],
                           logic signed [31:0] b [3], logic signed [15:0] n [3]);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    kind_i = kind;
    pos_a_x_i = a[0]; pos_a_y_i = a[1]; pos_a_z_i = a[2];
    pos_b_x_i = b[0]; pos_b_y_i = b[1]; pos_b_z_i = b[2];
    normal_x_i = n[0]; normal_y_i = n[1]; normal_z_i = n[2];
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(solve_contact(kind, a, b, n));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 10) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegOffX:  off_x = longint'(signed'(data));
      RegOffY:  off_y = longint'(signed'(data));
      RegOffZ:  off_z = longint'(signed'(data));
      default:  stiff = longint'(data[16:0]);
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] st);
    drain();
    write_reg(RegOffX, ox);
    write_reg(RegOffY, oy);
    write_reg(RegOffZ, oz);
    write_reg(RegStiff, st);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_normal();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic send_random(int count);
    logic signed [31:0] a [3], b [3];
    logic signed [15:0] n [3];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_pos();
        b[i] = ($urandom_range(0, 2) == 0) ? rand_pos() : a[i] + rand_pos() / 256;
        n[i] = rand_normal();
      end
      send_word(1'($urandom_range(0, 1)), a, b, n);
    end
  endtask

  task automatic test_directed;
    logic signed [31:0] a [3], b [3];
    logic signed [15:0] n [3];
    for (int m = 0; m < 2; m++) begin
      a = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000};
      b = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000};
      n = '{16'sd16384, 16'sd0, 16'sd0};
      send_word(1'(m), a, b, n);
      n = '{-16'sd16384, 16'sd0, 16'sd0};
      send_word(1'(m), b, a, n);
      a = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000};
      b = a;
      send_word(1'(m), a, b, n);
      a = '{32'sh0003_0000, -32'sh0002_0000, 32'sh0001_8000};
      b = '{-32'sh0001_0000, 32'sh0004_0000, 32'sh0000_0001};
      n = '{16'sd9459, 16'sd9459, 16'sd9459};
      send_word(1'(m), a, b, n);
      n = '{16'sh7FFF, 16'sh8000, 16'sd0};
      send_word(1'(m), a, b, n);
      n = '{16'sd0, 16'sd0, 16'sd0};
      send_word(1'(m), a, b, n);
      n = '{16'sd0, 16'sd0, 16'sd16384};
      send_word(1'(m), a, b, n);
      a = '{32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000};
      b = '{32'sh0001_0000, 32'sh0005_0000, 32'sh0000_0000};
      n = '{16'sd16384, 16'sd0, 16'sd0};
      send_word(1'(m), a, b, n);
      n = '{16'sd0, 16'sd16384, 16'sd0};
      send_word(1'(m), a, b, n);
    end
  endtask

  task automatic test_directed_offset;
    set_config(32'h0002_0000, 32'h0000_0000, 32'h0000_0001, 32'd65536);
    test_directed();
  endtask

  task automatic test_random_phases;
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_random(250);
    set_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd65536);
    send_random(250);
    set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd65536);
    send_random(250);
    set_config($urandom, $urandom, $urandom, 32'd1);
    send_random(250);
    for (int ph = 0; ph < 3; ph++) begin
      set_config($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000,
                 $urandom_range(0, 1) ? $urandom : 32'h0,
                 $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                 $urandom_range(0, 65536));
      send_random(230);
    end
  endtask

  initial begin
    off_x = 0; off_y = 0; off_z = 0; stiff = 65536;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_directed_offset();
    test_random_phases();
    drain();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
